[design/cadl_pkg.sv]
// Shared widths, register codes and saturation helper for the comb/allpass delay line.
`default_nettype none

package cadl_pkg;

   localparam int SAMPLE_W       = 24;
   localparam int DELAY_W        = 28;
   localparam int GAIN_W         = 18;
   localparam int FRAC_W         = 16;
   localparam int WHOLE_W        = DELAY_W - FRAC_W;
   localparam int WIDE_W         = 28;
   localparam int RING_DEPTH_DEF = 4096;
   localparam int CSR_INDEX_W    = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOPOLOGY    = 2'd0,
      CSR_INTERPOLATE = 2'd1,
      CSR_GAIN        = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       en;
      sample_type data;
   } store_wr_type;

   function automatic sample_type sat_sample(input logic signed [WIDE_W-1:0] v);
      sample_type max_s;
      sample_type min_s;
      max_s = {1'b0, {(SAMPLE_W-1){1'b1}}};
      min_s = {1'b1, {(SAMPLE_W-1){1'b0}}};
      if (v > WIDE_W'(max_s)) begin
         return max_s;
      end else if (v < WIDE_W'(min_s)) begin
         return min_s;
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

[design/cadl_tap_store.sv]
// Sample ring buffer: synchronous RAM, write pointer and fill tracking for unwritten entries.
`default_nettype none

module cadl_tap_store #(
   parameter int RING_DEPTH = cadl_pkg::RING_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   output      cadl_pkg::sample_type          rd_data,
   input  wire cadl_pkg::store_wr_type        wr,
   output      logic [$clog2(RING_DEPTH)-1:0] wp
);
   import cadl_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);

   logic [SAMPLE_W-1:0] mem [RING_DEPTH];
   logic [SAMPLE_W-1:0] q_ff;
   logic                rd_ok_ff;
   logic [AW-1:0]       wp_ff;
   logic [AW-1:0]       wp_in;
   logic                wrapped_ff;
   logic                wrapped_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wp_ff] <= wr.data;
      end
      q_ff <= mem[rd_addr];
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff <= wrapped_ff || (rd_addr < wp_ff);
      end
   end

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (wr.en) begin
         if (wp_ff == AW'(RING_DEPTH - 1)) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign rd_data = rd_ok_ff ? sample_type'(q_ff) : '0;
   assign wp      = wp_ff;

endmodule

`default_nettype wire

[design/comb_allpass_delay_line.sv]
// Only ST_IDLE takes a beat; ST_TAP1, ST_BLEND and ST_GAIN follow, then ST_WB waits
// until any earlier result is taken. Two reads through the single RAM read port, a
// blend multiply and a gain multiply run in sequence, then the write-back. The next
// beat is taken while a finished result still waits on the rsp side.
// Reset is synchronous; the buffer reads as zero until written, with no clearing pass.
`default_nettype none

module comb_allpass_delay_line #(
   parameter int RING_DEPTH = cadl_pkg::RING_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic signed [cadl_pkg::SAMPLE_W-1:0] req_sample_in,
   input  wire logic [cadl_pkg::DELAY_W-1:0]         req_delay_amount,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic signed [cadl_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire cadl_pkg::csr_index_type              csr_index,
   input  wire logic [cadl_pkg::GAIN_W-1:0]          csr_data
);
   import cadl_pkg::*;

   localparam int AW  = $clog2(RING_DEPTH);
   localparam int CW  = ((AW > WHOLE_W) ? AW : WHOLE_W) + 1;
   localparam int PFW = SAMPLE_W + 1 + FRAC_W + 1;
   localparam int PXW = GAIN_W + SAMPLE_W;
   localparam int PGW = GAIN_W + SAMPLE_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAP1,
      ST_BLEND,
      ST_GAIN,
      ST_WB
   } state_type;

   // configuration
   logic                     topology_ff;
   logic                     interp_ff;
   logic signed [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         topology_ff <= 1'b0;
         interp_ff   <= 1'b0;
         gain_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TOPOLOGY:    topology_ff <= csr_data[0];
            CSR_INTERPOLATE: interp_ff   <= csr_data[0];
            CSR_GAIN:        gain_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // tap address from the incoming beat
   logic [WHOLE_W-1:0] whole_raw;
   logic [AW-1:0]      whole;
   logic [FRAC_W-1:0]  frac;
   logic [AW:0]        diff;
   logic [AW-1:0]      r0;
   logic [AW-1:0]      r1;
   logic [AW-1:0]      wp;

   always_comb begin
      whole_raw = req_delay_amount[DELAY_W-1:FRAC_W];
      if (whole_raw == '0) begin
         whole = AW'(1);
         frac  = '0;
      end else if (CW'(whole_raw) >= CW'(RING_DEPTH)) begin
         whole = AW'(RING_DEPTH - 1);
         frac  = '0;
      end else begin
         whole = AW'(whole_raw);
         frac  = interp_ff ? req_delay_amount[FRAC_W-1:0] : '0;
      end
      diff = {1'b0, wp} - {1'b0, whole};
      r0   = diff[AW] ? (diff[AW-1:0] + AW'(RING_DEPTH)) : diff[AW-1:0];
      r1   = (r0 == '0) ? AW'(RING_DEPTH - 1) : (r0 - AW'(1));
   end

   // datapath and control
   state_type             state_ff, state_in;
   sample_type            x_ff, x_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [AW-1:0]         r1_ff, r1_in;
   sample_type            s0_ff, s0_in;
   logic signed [PXW-1:0] px_ff, px_in;
   logic signed [PFW-1:0] pf_ff, pf_in;
   sample_type            dly_ff, dly_in;
   logic signed [PGW-1:0] pg_ff, pg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            rsp_data_ff, rsp_data_in;

   sample_type              rd_data;
   logic [AW-1:0]           rd_addr;
   store_wr_type            wr;
   logic                    wb_fire;
   logic signed [SAMPLE_W:0] dif;
   logic signed [PFW-1:0]   pf_rnd;
   logic signed [SAMPLE_W:0] mul_op;
   logic signed [SAMPLE_W:0] sum;
   logic signed [PGW-1:0]   pg_rnd;
   logic signed [PXW-1:0]   px_rnd;
   sample_type              stored;

   assign req_ready = (state_ff == ST_IDLE);
   assign wb_fire   = (state_ff == ST_WB) && (!rsp_valid_ff || rsp_ready);
   assign rd_addr   = (state_ff == ST_IDLE) ? r0 : r1_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      frac_in      = frac_ff;
      r1_in        = r1_ff;
      s0_in        = s0_ff;
      px_in        = px_ff;
      pf_in        = pf_ff;
      dly_in       = dly_ff;
      pg_in        = pg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      stored       = '0;

      dif    = (SAMPLE_W+1)'(rd_data) - (SAMPLE_W+1)'(s0_ff);
      pf_rnd = pf_ff + PFW'(1 << (FRAC_W - 1));
      sum    = (SAMPLE_W+1)'(x_ff) + (SAMPLE_W+1)'(dly_ff);
      pg_rnd = pg_ff + PGW'(1 << (FRAC_W - 1));
      px_rnd = px_ff + PXW'(1 << (FRAC_W - 1));
      mul_op = topology_ff ? (SAMPLE_W+1)'(dly_in) : sum;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               frac_in  = frac;
               r1_in    = r1;
               state_in = ST_TAP1;
            end
         end
         ST_TAP1: begin
            s0_in    = rd_data;
            px_in    = gain_ff * x_ff;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            // s0*(1-f) + s1*f rewritten as s0 + (s1-s0)*f
            pf_in    = dif * $signed({1'b0, frac_ff});
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            dly_in   = SAMPLE_W'((SAMPLE_W+2)'(s0_ff) + pf_rnd[PFW-1:FRAC_W]);
            // comb feedback scales the fresh sum, not the registered one
            mul_op   = topology_ff ? (SAMPLE_W+1)'(dly_in)
                                   : (SAMPLE_W+1)'(x_ff) + (SAMPLE_W+1)'(dly_in);
            pg_in    = gain_ff * mul_op;
            state_in = ST_WB;
         end
         ST_WB: begin
            if (topology_ff) begin
               stored      = sat_sample(WIDE_W'(x_ff)
                                        + WIDE_W'($signed(pg_rnd[PGW-1:FRAC_W])));
               rsp_data_in = sat_sample(WIDE_W'(dly_ff)
                                        - WIDE_W'($signed(px_rnd[PXW-1:FRAC_W])));
            end else begin
               stored      = sat_sample(WIDE_W'($signed(pg_rnd[PGW-1:FRAC_W])));
               rsp_data_in = sat_sample(WIDE_W'(sum));
            end
            if (wb_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rsp_data_in = rsp_data_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      frac_ff     <= frac_in;
      r1_ff       <= r1_in;
      s0_ff       <= s0_in;
      px_ff       <= px_in;
      pf_ff       <= pf_in;
      dly_ff      <= dly_in;
      pg_ff       <= pg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign wr.en   = wb_fire;
   assign wr.data = stored;

   cadl_tap_store #(
      .RING_DEPTH (RING_DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr),
      .wp      (wp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // checks
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("beat accepted while another is in flight");

   a_wp_moves_on_write: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(wb_fire) |-> $stable(wp))
      else $error("write pointer moved without a write-back");

   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_WB))
      else $error("result offered outside write-back");

   a_whole_tap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GAIN && frac_ff == '0 |-> dly_in == s0_ff)
      else $error("integer delay did not return the tap unchanged");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for comb_allpass_delay_line: queued beats, inline predictor, scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cadl_pkg::*;

   localparam int DEPTH       = RING_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      sample_type         smp;
      logic [DELAY_W-1:0] dly;
   } tap_item_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   sample_type          req_sample_in    = '0;
   logic [DELAY_W-1:0]  req_delay_amount = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   sample_type          rsp_sample_out;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index        = CSR_TOPOLOGY;
   logic [GAIN_W-1:0]   csr_data         = '0;

   // predictor state
   bit                  topo_q   = 1'b0;
   bit                  interp_q = 1'b0;
   longint              gain_q   = 0;
   longint              delay_mem [DEPTH];
   int                  wr_ptr   = 0;

   tap_item_type        feed_q[$];
   sample_type          echo_q[$];
   tap_item_type        drv_item;
   sample_type          want;

   bit                  req_took  = 1'b0;
   bit                  idle_on   = 1'b1;
   int                  req_gap   = 0;
   int                  rsp_gap   = 0;
   int                  hold_req  = 0;
   int                  hold_left = 0;
   int                  errors    = 0;
   int                  cycles    = 0;

   comb_allpass_delay_line uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_in    (req_sample_in),
      .req_delay_amount (req_delay_amount),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // Q16 shift, rounded half up
   function automatic longint rnd16(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic sample_type run_delay_line(sample_type x_in, logic [DELAY_W-1:0] amt_in);
      longint x, amt, whole, frac, r0, r1, tap, sum, out_v, kept;
      x   = x_in;
      amt = amt_in;
      if (interp_q) begin
         if (amt < 65536) amt = 65536;
         if (amt >= longint'(DEPTH) * 65536) amt = longint'(DEPTH - 1) * 65536;
         whole = amt >> 16;
         frac  = amt & 16'hFFFF;
      end else begin
         whole = amt >> 16;
         frac  = 0;
         if (whole < 1) whole = 1;
         if (whole >= DEPTH) whole = DEPTH - 1;
      end
      r0 = (wr_ptr + DEPTH - whole) % DEPTH;
      r1 = (r0 + DEPTH - 1) % DEPTH;
      if (frac == 0) begin
         tap = delay_mem[r0];
      end else begin
         tap = clip24(rnd16(delay_mem[r0] * (65536 - frac) + delay_mem[r1] * frac));
      end
      if (!topo_q) begin
         sum   = x + tap;
         out_v = clip24(sum);
         kept  = clip24(rnd16(gain_q * sum));
      end else begin
         kept  = clip24(x + rnd16(gain_q * tap));
         out_v = clip24(tap - rnd16(gain_q * x));
      end
      delay_mem[wr_ptr] = kept;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      return sample_type'(out_v);
   endfunction

   function automatic tap_item_type random_item();
      tap_item_type it;
      int           sk;
      int           dk;
      sk = $urandom_range(0, 9);
      dk = $urandom_range(0, 19);
      case (sk) inside
         0:       it.smp = sample_type'(8388607);
         1:       it.smp = sample_type'(-8388608);
         [2:4]:   it.smp = sample_type'(int'($urandom_range(0, 8191)) - 4096);
         default: it.smp = sample_type'($urandom);
      endcase
      case (dk)
         0:       it.dly = DELAY_W'($urandom);
         1:       it.dly = DELAY_W'($urandom_range(0, 65535));
         2:       it.dly = DELAY_W'(($urandom_range(4090, 4200) << 16) | $urandom_range(0, 65535));
         3:       it.dly = DELAY_W'((4095 << 16) | $urandom_range(0, 65535));
         4:       it.dly = DELAY_W'($urandom_range(1, 48) << 16);
         default: it.dly = DELAY_W'(($urandom_range(1, 48) << 16) | $urandom_range(0, 65535));
      endcase
      return it;
   endfunction

   task automatic queue_item(int s, int unsigned d);
      tap_item_type it;
      it.smp = sample_type'(s);
      it.dly = DELAY_W'(d);
      feed_q.push_back(it);
   endtask

   // extremes of both fields, clamp corners, fractions
   task automatic queue_directed();
      queue_item(8388607, 1 << 16);
      queue_item(-8388608, 1 << 16);
      queue_item(0, 0);                          // short delay
      queue_item(4660, 16'h8000);                // below one, with fraction
      queue_item(-1, 28'hFFFFFFF);               // long delay
      queue_item(123456, 4096 << 16);
      queue_item(-654321, (4095 << 16) | 16'h8000); // oldest tap under write pointer
      queue_item(8388607, (1 << 16) | 16'hC000);
      queue_item(-8388608, (2 << 16) | 16'h0001);
      queue_item(1, (3 << 16) | 16'hFFFF);
      queue_item(8388607, 1 << 16);
      queue_item(-8388608, 1 << 16);
   endtask

   task automatic write_reg(csr_index_type idx, logic [GAIN_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (feed_q.size() != 0 || req_valid || echo_q.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         req_took = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (idle_on && feed_q.size() != 0 && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(1, 14) - 1;
            req_valid <= 1'b0;
         end else if (feed_q.size() != 0) begin
            drv_item = feed_q.pop_front();
            req_sample_in    <= drv_item.smp;
            req_delay_amount <= drv_item.dly;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOPOLOGY:    topo_q   = csr_data[0];
               CSR_INTERPOLATE: interp_q = csr_data[0];
               CSR_GAIN:        gain_q   = longint'($signed(csr_data));
               default:         ;
            endcase
         end
         if (req_valid && req_ready) begin
            echo_q.push_back(run_delay_line(req_sample_in, req_delay_amount));
            req_took = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (echo_q.size() == 0) begin
               $display("%0t: unexpected sample_out beat, expected none, got %0d",
                        $time, rsp_sample_out);
               errors++;
            end else begin
               want = echo_q.pop_front();
               if (rsp_sample_out !== want) begin
                  $display("%0t: sample_out mismatch, expected %0d, got %0d",
                           $time, want, rsp_sample_out);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int gain_pick [8];
      int g;
      gain_pick = '{0, 65536, -65536, 131071, -131072, 0, 0, 0};
      foreach (delay_mem[i]) delay_mem[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(CSR_TOPOLOGY, '0);
      write_reg(CSR_INTERPOLATE, '0);
      write_reg(CSR_GAIN, 18'h1FFFF);
      queue_directed();
      wait_drained();

      write_reg(CSR_TOPOLOGY, 18'd1);
      write_reg(CSR_INTERPOLATE, 18'd1);
      write_reg(CSR_GAIN, 18'h20000);
      write_reg(csr_index_type'(2'd3), 18'h15555);   // unused index, must not touch gain
      queue_directed();

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         if (p < 5) g = gain_pick[p];
         else if (p == 7) g = int'($urandom_range(0, 8191)) - 4096;
         else g = int'($urandom_range(0, 262143)) - 131072;
         write_reg(CSR_TOPOLOGY, GAIN_W'(p % 2));
         write_reg(CSR_INTERPOLATE, GAIN_W'((p / 2) % 2));
         write_reg(CSR_GAIN, GAIN_W'(g));
         idle_on = !(p == 3 || p == 7);
         if (p == 1) hold_req = 250;   // long stall so the input side backs up
         repeat (115) feed_q.push_back(random_item());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[comb_allpass_delay_line.f]
design/cadl_pkg.sv
design/cadl_tap_store.sv
design/comb_allpass_delay_line.sv
sim/tb_top.sv
